// File: hw/rtl/jsu_pkg.sv
// Package for the JSON string unescaper: item structs, result kinds,
// character codes and the UTF-8 encoder function.
// No dependencies.
`default_nettype none

package jsu_pkg;

	// One input item: a text byte or the end-of-text mark
	typedef struct packed {
		logic [7:0] in_byte;
		logic       text_end;
	} txt_item_t;

	// One result item
	typedef struct packed {
		logic [7:0] out_byte;
		logic [2:0] kind;
		logic       last;
	} res_item_t;

	// Result kinds
	localparam logic [2:0] KIND_BYTE    = 3'd0;
	localparam logic [2:0] KIND_CLOSED  = 3'd1;
	localparam logic [2:0] KIND_NOQUOTE = 3'd2;
	localparam logic [2:0] KIND_UNTERM  = 3'd3;
	localparam logic [2:0] KIND_SHORT   = 3'd4;

	// Character codes
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_U      = 8'h75;

	// Surrogate ranges
	localparam logic [15:0] HIGH_LO = 16'hD800;
	localparam logic [15:0] HIGH_HI = 16'hDC00;

	// Encoded code point: up to four bytes, b[0] sent first
	typedef struct packed {
		logic [3:0][7:0] b;
		logic [2:0]      n;
	} utf8_seq_t;

	// UTF-8 encoding of a 32-bit code point, lead byte truncated to 8 bits
	function automatic utf8_seq_t utf8_encode(input logic [31:0] cp);
		utf8_seq_t s;
		s.b = '0;
		if (cp < 32'h0000_0080) begin
			s.b[0] = cp[7:0];
			s.n    = 3'd1;
		end else if (cp < 32'h0000_0800) begin
			s.b[0] = 8'hC0 | cp[13:6];
			s.b[1] = {2'b10, cp[5:0]};
			s.n    = 3'd2;
		end else if (cp < 32'h0001_0000) begin
			s.b[0] = 8'hE0 | cp[19:12];
			s.b[1] = {2'b10, cp[11:6]};
			s.b[2] = {2'b10, cp[5:0]};
			s.n    = 3'd3;
		end else begin
			s.b[0] = 8'hF0 | cp[25:18];
			s.b[1] = {2'b10, cp[17:12]};
			s.b[2] = {2'b10, cp[11:6]};
			s.b[3] = {2'b10, cp[5:0]};
			s.n    = 3'd4;
		end
		return s;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/json_string_unescape_utf8.sv
// JSON string unescaper with UTF-8 output: top level.
// Depends on jsu_pkg.
`default_nettype none
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------
//  txt     | in        | txt_valid / txt_stall | txt_data  (txt_item_t)
//  res     | out       | res_valid / res_stall | res_data  (res_item_t)
//
// Entry register, then combinational decode into a registered bundle of up to four
// results; the bundle offers one result per cycle while res_stall is low.
// Reset returns the decoder to awaiting the opening quote with empty stages.
// txt_stall is high while the entry register is full and the bundle is
// neither empty nor handing over its final result.

module json_string_unescape_utf8
	import jsu_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      txt_valid,
	output logic           txt_stall,
	input  wire txt_item_t txt_data,
	output logic           res_valid,
	input  wire logic      res_stall,
	output res_item_t      res_data
);

	typedef enum logic [2:0] {
		PH_AWAIT,
		PH_STRING,
		PH_ESCAPE,
		PH_HEX,
		PH_HIGH,
		PH_HIGH_BS,
		PH_HEX_LOW
	} phase_t;

	// Entry register
	logic      vld_s1;
	txt_item_t item_s1;

	// Decoder state
	phase_t      phase_q;
	logic [15:0] code_q;
	logic [2:0]  digits_q;
	logic        stop_q;
	logic [15:0] high_q;

	// Result bundle
	logic [7:0] rb_q [4];
	logic [2:0] rk_q [4];
	logic [2:0] cnt_q;
	logic [1:0] idx_q;

	logic take, fin, bundle_free, advance;

	// Output side of the bundle
	assign res_valid         = (cnt_q != 3'd0);
	assign res_data.out_byte = rb_q[idx_q];
	assign res_data.kind     = rk_q[idx_q];
	assign res_data.last     = ({1'b0, idx_q} == (cnt_q - 3'd1));

	assign take        = res_valid && !res_stall;
	assign fin         = take && res_data.last;
	assign bundle_free = (cnt_q == 3'd0) || fin;
	assign advance     = vld_s1 && bundle_free;
	assign txt_stall   = vld_s1 && !bundle_free;

	// Entry register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!txt_stall) begin
			vld_s1 <= txt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (txt_valid && !txt_stall) begin
			item_s1 <= txt_data;
		end
	end

	// Hex digit decode
	logic [7:0]  c;
	logic        eot;
	logic        dvalid;
	logic [3:0]  dval;
	logic [15:0] code_n;
	logic        stop_n;
	logic [2:0]  dig_n;
	logic        hex_done;
	logic [31:0] pair_cp;

	assign c   = item_s1.in_byte;
	assign eot = item_s1.text_end;

	always_comb begin
		dvalid = 1'b1;
		dval   = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			dval = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			dval = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			dval = 4'(c - 8'h37);
		end else begin
			dvalid = 1'b0;
		end
	end

	assign code_n   = (!stop_q && dvalid) ? {code_q[11:0], dval} : code_q;
	assign stop_n   = stop_q || !dvalid;
	assign dig_n    = digits_q + 3'd1;
	assign hex_done = (dig_n == 3'd4);
	// Joined pair, modulo 2^32, second half not range checked
	assign pair_cp  = 32'h0001_0000 + ((32'(high_q) - 32'(HIGH_LO)) << 10)
		+ (32'(code_n) - 32'(HIGH_HI));

	// Next-state and result selection for the registered item
	phase_t      ph_d;
	logic [15:0] code_d;
	logic [2:0]  dig_d;
	logic        stop_d;
	logic [15:0] high_d;
	logic        clr;
	logic        do_str, do_esc;
	logic        enc_use;
	logic [31:0] enc_cp;
	logic        tail_en;
	logic [2:0]  tail_kind;
	logic [7:0]  tail_byte;

	always_comb begin
		ph_d      = phase_q;
		code_d    = code_q;
		dig_d     = digits_q;
		stop_d    = stop_q;
		high_d    = high_q;
		clr       = 1'b0;
		do_str    = 1'b0;
		do_esc    = 1'b0;
		enc_use   = 1'b0;
		enc_cp    = 32'(high_q);
		tail_en   = 1'b0;
		tail_kind = KIND_BYTE;
		tail_byte = 8'h00;

		case (phase_q)
			PH_AWAIT: begin
				if (!eot) begin
					if (c == CH_QUOTE) begin
						ph_d = PH_STRING;
					end else begin
						tail_en   = 1'b1;
						tail_kind = KIND_NOQUOTE;
					end
				end
			end
			PH_STRING, PH_ESCAPE: begin
				if (eot) begin
					tail_en   = 1'b1;
					tail_kind = KIND_UNTERM;
					clr       = 1'b1;
				end else if (phase_q == PH_STRING) begin
					do_str = 1'b1;
				end else begin
					do_esc = 1'b1;
				end
			end
			PH_HEX, PH_HEX_LOW: begin
				if (eot) begin
					tail_en   = 1'b1;
					tail_kind = KIND_SHORT;
					clr       = 1'b1;
				end else if (!hex_done) begin
					code_d = code_n;
					dig_d  = dig_n;
					stop_d = stop_n;
				end else begin
					code_d = '0;
					dig_d  = '0;
					stop_d = 1'b0;
					if (phase_q == PH_HEX && code_n >= HIGH_LO && code_n < HIGH_HI) begin
						high_d = code_n;
						ph_d   = PH_HIGH;
					end else begin
						enc_use = 1'b1;
						enc_cp  = (phase_q == PH_HEX) ? 32'(code_n) : pair_cp;
						ph_d    = PH_STRING;
					end
				end
			end
			PH_HIGH: begin
				if (eot) begin
					enc_use   = 1'b1;
					tail_en   = 1'b1;
					tail_kind = KIND_UNTERM;
					clr       = 1'b1;
				end else if (c == CH_BSLASH) begin
					ph_d = PH_HIGH_BS;
				end else begin
					enc_use = 1'b1;
					do_str  = 1'b1;
				end
			end
			PH_HIGH_BS: begin
				if (eot) begin
					enc_use   = 1'b1;
					tail_en   = 1'b1;
					tail_kind = KIND_UNTERM;
					clr       = 1'b1;
				end else if (c == CH_U) begin
					ph_d   = PH_HEX_LOW;
					code_d = '0;
					dig_d  = '0;
					stop_d = 1'b0;
				end else begin
					enc_use = 1'b1;
					do_esc  = 1'b1;
				end
			end
			default: begin
				clr = 1'b1;
			end
		endcase

		// Plain string byte
		if (do_str) begin
			if (c == CH_QUOTE) begin
				tail_en   = 1'b1;
				tail_kind = KIND_CLOSED;
				clr       = 1'b1;
			end else if (c == CH_BSLASH) begin
				ph_d = PH_ESCAPE;
			end else begin
				tail_en   = 1'b1;
				tail_byte = c;
				ph_d      = PH_STRING;
			end
		end

		// Byte after a backslash
		if (do_esc) begin
			ph_d    = PH_STRING;
			tail_en = 1'b1;
			case (c)
				CH_N:    tail_byte = 8'h0A;
				CH_T:    tail_byte = 8'h09;
				CH_R:    tail_byte = 8'h0D;
				CH_B:    tail_byte = 8'h08;
				CH_F:    tail_byte = 8'h0C;
				CH_U: begin
					tail_en = 1'b0;
					ph_d    = PH_HEX;
					code_d  = '0;
					dig_d   = '0;
					stop_d  = 1'b0;
				end
				default: tail_byte = c;
			endcase
		end

		// Close or error: back to awaiting the quote
		if (clr) begin
			ph_d   = PH_AWAIT;
			code_d = '0;
			dig_d  = '0;
			stop_d = 1'b0;
			high_d = '0;
		end
	end

	// Assemble the bundle: encoded bytes first, then the single tail result
	utf8_seq_t  enc;
	logic [2:0] n_used;
	logic [2:0] cnt_d;
	logic [7:0] rb_d [4];
	logic [2:0] rk_d [4];

	assign enc    = utf8_encode(enc_cp);
	assign n_used = enc_use ? enc.n : 3'd0;
	assign cnt_d  = n_used + {2'b00, tail_en};

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			if (3'(i) < n_used) begin
				rb_d[i] = enc.b[2'(i)];
				rk_d[i] = KIND_BYTE;
			end else begin
				rb_d[i] = tail_byte;
				rk_d[i] = tail_kind;
			end
		end
	end

	// Decoder state and bundle control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_AWAIT;
			code_q   <= '0;
			digits_q <= '0;
			stop_q   <= 1'b0;
			high_q   <= '0;
			cnt_q    <= '0;
			idx_q    <= '0;
		end else begin
			if (advance) begin
				phase_q  <= ph_d;
				code_q   <= code_d;
				digits_q <= dig_d;
				stop_q   <= stop_d;
				high_q   <= high_d;
				cnt_q    <= cnt_d;
				idx_q    <= '0;
			end else if (fin) begin
				cnt_q <= '0;
				idx_q <= '0;
			end else if (take) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	// Bundle payload
	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = 0; i < 4; i++) begin
				rb_q[i] <= rb_d[i];
				rk_q[i] <= rk_d[i];
			end
		end
	end

	// Checks
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (cnt_q <= 3'd4 && {1'b0, idx_q} < cnt_q))
		else $error("bundle index out of range");

	a_drain_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(fin && !advance) |=> !res_valid)
		else $error("bundle not emptied after its final result");

	a_high_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HIGH || phase_q == PH_HIGH_BS || phase_q == PH_HEX_LOW)
		|-> (high_q >= HIGH_LO && high_q < HIGH_HI))
		else $error("held high surrogate out of range");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=> (res_valid && $stable(cnt_q) && $stable(idx_q)))
		else $error("stalled bundle changed");

endmodule

`default_nettype wire

// File: tb/tb_json_string_unescape_utf8.sv
// Self-checking testbench for json_string_unescape_utf8: a directed table, then random
// quoted strings with escapes and \u codes, checked against an in-bench decoder model.
// Depends on jsu_pkg and the json_string_unescape_utf8 RTL.
`default_nettype none

module tb_json_string_unescape_utf8;
	import jsu_pkg::*;

	// Decoder phases of the in-bench model
	typedef enum logic [2:0] {
		ST_AWAIT, ST_STRING, ST_ESCAPE, ST_HEX, ST_HIGH, ST_HIGH_BS, ST_HEX_LOW
	} dec_phase_t;

	// One stimulus row: the item, and a typed-in expectation (none or one result)
	typedef struct packed {
		txt_item_t it;
		logic      typed;
		logic      has_res;
		res_item_t res;
	} drow_t;

	localparam int N_DIRECTED = 27;
	localparam int N_RANDOM   = 283;

	logic      clk       = 1'b0;
	logic      arst_n;
	logic      txt_valid = 1'b0;
	logic      txt_stall;
	txt_item_t txt_data  = '0;
	logic      res_valid;
	logic      res_stall = 1'b0;
	res_item_t res_data;

	json_string_unescape_utf8 dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.txt_valid (txt_valid),
		.txt_stall (txt_stall),
		.txt_data  (txt_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

	always #5 clk = ~clk;

	drow_t     stim_q[$];
	drow_t     cur_row = '0;
	res_item_t bytes_due[$];
	int        errors  = 0;
	int        n_taken = 0;
	int        n_total;

	// ---------------------------------------------------------------
	// Decoder model
	// ---------------------------------------------------------------
	dec_phase_t  ph         = ST_AWAIT;
	logic [15:0] acc_code   = '0;
	logic [2:0]  n_digits   = '0;
	logic        run_halted = 1'b0;
	logic [15:0] hi_code    = '0;
	res_item_t   pend [4];
	int          pend_n;

	task automatic reset_decoder();
		ph         = ST_AWAIT;
		acc_code   = '0;
		n_digits   = '0;
		run_halted = 1'b0;
		hi_code    = '0;
	endtask

	task automatic put_res(input logic [7:0] b, input logic [2:0] k);
		if (pend_n < 4) begin
			pend[pend_n] = '{out_byte: b, kind: k, last: 1'b0};
			pend_n++;
		end
	endtask

	// UTF-8 bytes of one code point, lead byte cut to 8 bits
	task automatic put_code_point(input logic [31:0] cp);
		logic [31:0] t;
		if (cp < 32'h80) begin
			put_res(cp[7:0], KIND_BYTE);
		end else if (cp < 32'h800) begin
			t = 32'hC0 | (cp >> 6);
			put_res(t[7:0], KIND_BYTE);
			t = 32'h80 | (cp & 32'h3F);
			put_res(t[7:0], KIND_BYTE);
		end else if (cp < 32'h10000) begin
			t = 32'hE0 | (cp >> 12);
			put_res(t[7:0], KIND_BYTE);
			t = 32'h80 | ((cp >> 6) & 32'h3F);
			put_res(t[7:0], KIND_BYTE);
			t = 32'h80 | (cp & 32'h3F);
			put_res(t[7:0], KIND_BYTE);
		end else begin
			t = 32'hF0 | (cp >> 18);
			put_res(t[7:0], KIND_BYTE);
			t = 32'h80 | ((cp >> 12) & 32'h3F);
			put_res(t[7:0], KIND_BYTE);
			t = 32'h80 | ((cp >> 6) & 32'h3F);
			put_res(t[7:0], KIND_BYTE);
			t = 32'h80 | (cp & 32'h3F);
			put_res(t[7:0], KIND_BYTE);
		end
	endtask

	task automatic begin_digits(input dec_phase_t p);
		ph         = p;
		acc_code   = '0;
		n_digits   = '0;
		run_halted = 1'b0;
	endtask

	// Byte inside the string body
	task automatic on_plain(input logic [7:0] c);
		if (c == CH_QUOTE) begin
			put_res(8'h00, KIND_CLOSED);
			reset_decoder();
		end else if (c == CH_BSLASH) begin
			ph = ST_ESCAPE;
		end else begin
			put_res(c, KIND_BYTE);
			ph = ST_STRING;
		end
	endtask

	// Byte after a backslash
	task automatic on_escaped(input logic [7:0] c);
		ph = ST_STRING;
		case (c)
			CH_N:    put_res(8'h0A, KIND_BYTE);
			CH_T:    put_res(8'h09, KIND_BYTE);
			CH_R:    put_res(8'h0D, KIND_BYTE);
			CH_B:    put_res(8'h08, KIND_BYTE);
			CH_F:    put_res(8'h0C, KIND_BYTE);
			CH_U:    begin_digits(ST_HEX);
			default: put_res(c, KIND_BYTE);
		endcase
	endtask

	// Hex value of a character, 16 when it is not a hex digit
	function automatic logic [4:0] digit_of(input logic [7:0] c);
		logic [7:0] d;
		d = 8'd16;
		if (c >= "0" && c <= "9")
			d = c - 8'h30;
		else if (c >= "a" && c <= "f")
			d = c - 8'h61 + 8'd10;
		else if (c >= "A" && c <= "F")
			d = c - 8'h41 + 8'd10;
		return d[4:0];
	endfunction

	// One of the four digit slots of a \u escape
	task automatic on_digit(input logic [7:0] c);
		logic [4:0]  d;
		logic [31:0] cp;
		d = digit_of(c);
		if (!run_halted && d < 5'd16)
			acc_code = {acc_code[11:0], d[3:0]};
		else
			run_halted = 1'b1;
		n_digits = n_digits + 3'd1;
		if (n_digits >= 3'd4) begin
			if (ph == ST_HEX) begin
				if (acc_code >= HIGH_LO && acc_code < HIGH_HI) begin
					hi_code = acc_code;
					ph      = ST_HIGH;
				end else begin
					put_code_point({16'h0, acc_code});
					ph = ST_STRING;
				end
			end else begin
				cp = 32'h10000 + (({16'h0, hi_code} - {16'h0, HIGH_LO}) << 10)
					+ ({16'h0, acc_code} - {16'h0, HIGH_HI});
				put_code_point(cp);
				ph = ST_STRING;
			end
			acc_code   = '0;
			n_digits   = '0;
			run_halted = 1'b0;
		end
	endtask

	// Expected results of one item, left in pend[0 .. pend_n-1]
	task automatic decode_item(input txt_item_t it);
		pend_n = 0;
		case (ph)
			ST_AWAIT: begin
				if (!it.text_end) begin
					if (it.in_byte == CH_QUOTE)
						ph = ST_STRING;
					else
						put_res(8'h00, KIND_NOQUOTE);
				end
			end
			ST_STRING, ST_ESCAPE: begin
				if (it.text_end) begin
					put_res(8'h00, KIND_UNTERM);
					reset_decoder();
				end else if (ph == ST_STRING) begin
					on_plain(it.in_byte);
				end else begin
					on_escaped(it.in_byte);
				end
			end
			ST_HEX, ST_HEX_LOW: begin
				if (it.text_end) begin
					put_res(8'h00, KIND_SHORT);
					reset_decoder();
				end else begin
					on_digit(it.in_byte);
				end
			end
			ST_HIGH: begin
				if (it.text_end) begin
					put_code_point({16'h0, hi_code});
					put_res(8'h00, KIND_UNTERM);
					reset_decoder();
				end else if (it.in_byte == CH_BSLASH) begin
					ph = ST_HIGH_BS;
				end else begin
					put_code_point({16'h0, hi_code});
					on_plain(it.in_byte);
				end
			end
			ST_HIGH_BS: begin
				if (it.text_end) begin
					put_code_point({16'h0, hi_code});
					put_res(8'h00, KIND_UNTERM);
					reset_decoder();
				end else if (it.in_byte == CH_U) begin
					begin_digits(ST_HEX_LOW);
				end else begin
					put_code_point({16'h0, hi_code});
					on_escaped(it.in_byte);
				end
			end
			default: reset_decoder();
		endcase
		if (pend_n > 0)
			pend[pend_n - 1].last = 1'b1;
	endtask

	// ---------------------------------------------------------------
	// Stimulus rows
	// ---------------------------------------------------------------
	function automatic drow_t pd(input logic [7:0] b, input logic e);
		drow_t r;
		r = '0;
		r.it = '{in_byte: b, text_end: e};
		return r;
	endfunction

	function automatic drow_t ty0(input logic [7:0] b, input logic e);
		drow_t r;
		r = pd(b, e);
		r.typed = 1'b1;
		return r;
	endfunction

	function automatic drow_t ty1(input logic [7:0] b, input logic e,
			input logic [7:0] ob, input logic [2:0] k);
		drow_t r;
		r = ty0(b, e);
		r.has_res = 1'b1;
		r.res = '{out_byte: ob, kind: k, last: 1'b1};
		return r;
	endfunction

	task automatic add_byte(input logic [7:0] b);
		stim_q.insert(stim_q.size(), pd(b, 1'b0));
	endtask

	// End mark with a junk byte that must be ignored
	task automatic add_end();
		stim_q.insert(stim_q.size(), pd(8'($urandom_range(0, 255)), 1'b1));
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v < 4'd10)
			return 8'h30 + v;
		else if ($urandom_range(0, 1))
			return 8'h61 + v - 8'd10;
		else
			return 8'h41 + v - 8'd10;
	endfunction

	task automatic add_hex4(input logic [15:0] v);
		for (int i = 3; i >= 0; i--)
			add_byte(hex_char(v[i*4 +: 4]));
	endtask

	task automatic add_uesc();
		add_byte(CH_BSLASH);
		add_byte(CH_U);
	endtask

	function automatic logic [15:0] pick_code();
		case ($urandom_range(0, 4))
			0:       return 16'($urandom_range(0, 16'h7F));
			1:       return 16'($urandom_range(16'h80, 16'h7FF));
			2:       return 16'($urandom_range(16'h0000, 16'hFFFF));
			3:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			default: return 16'($urandom_range(16'hE000, 16'hFFFF));
		endcase
	endfunction

	// Byte for a plain escape: the named ones, quote, slashes, or anything but u
	function automatic logic [7:0] pick_esc();
		logic [7:0] c;
		case ($urandom_range(0, 8))
			0:       c = CH_N;
			1:       c = CH_T;
			2:       c = CH_R;
			3:       c = CH_B;
			4:       c = CH_F;
			5:       c = CH_QUOTE;
			6:       c = CH_BSLASH;
			7:       c = "/";
			default: c = 8'($urandom_range(0, 255));
		endcase
		if (c == CH_U)
			c = CH_N;
		return c;
	endfunction

	function automatic logic [7:0] pick_plain();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		if (c == CH_QUOTE || c == CH_BSLASH)
			c = c ^ 8'h80;
		return c;
	endfunction

	// One random text: mostly well-formed strings, some noise and broken ones
	task automatic gen_text();
		int   nseg;
		int   k;
		logic ended;
		ended = 1'b0;
		if ($urandom_range(0, 9) == 0) begin
			// noise while awaiting the quote
			k = $urandom_range(1, 4);
			for (int i = 0; i < k; i++) begin
				if ($urandom_range(0, 3) == 0)
					add_end();
				else
					add_byte(8'($urandom_range(0, 255)));
			end
			return;
		end
		add_byte(CH_QUOTE);
		nseg = $urandom_range(0, 10);
		for (int s = 0; s < nseg && !ended; s++) begin
			case ($urandom_range(0, 9))
				0, 1, 2: add_byte(pick_plain());
				3: begin
					add_byte(CH_BSLASH);
					add_byte(pick_esc());
				end
				4, 5: begin
					add_uesc();
					add_hex4(pick_code());
				end
				6: begin
					// surrogate pair, second half sometimes not a low surrogate
					add_uesc();
					add_hex4(16'($urandom_range(16'hD800, 16'hDBFF)));
					add_uesc();
					if ($urandom_range(0, 3) == 0)
						add_hex4(pick_code());
					else
						add_hex4(16'($urandom_range(16'hDC00, 16'hDFFF)));
				end
				7: begin
					// lone high surrogate
					add_uesc();
					add_hex4(16'($urandom_range(16'hD800, 16'hDBFF)));
					case ($urandom_range(0, 4))
						0: add_byte(pick_plain());
						1: begin
							add_byte(CH_BSLASH);
							add_byte(pick_esc());
						end
						2: add_byte(CH_QUOTE);
						3: begin
							add_end();
							ended = 1'b1;
						end
						default: begin
							add_byte(CH_BSLASH);
							add_end();
							ended = 1'b1;
						end
					endcase
				end
				8: begin
					// digit run with a quote, backslash or random byte in one of the slots
					add_uesc();
					k = $urandom_range(0, 3);
					for (int i = 0; i < 4; i++) begin
						if (i == k) begin
							case ($urandom_range(0, 2))
								0:       add_byte(CH_QUOTE);
								1:       add_byte(CH_BSLASH);
								default: add_byte(8'($urandom_range(0, 255)));
							endcase
						end else begin
							add_byte(hex_char(4'($urandom_range(0, 15))));
						end
					end
				end
				default: begin
					// short \u escape cut by the end of text
					add_uesc();
					k = $urandom_range(0, 3);
					for (int i = 0; i < k; i++)
						add_byte(hex_char(4'($urandom_range(0, 15))));
					add_end();
					ended = 1'b1;
				end
			endcase
		end
		if (!ended) begin
			case ($urandom_range(0, 9))
				0: add_end();
				1: begin
					add_byte(CH_BSLASH);
					add_end();
				end
				default: add_byte(CH_QUOTE);
			endcase
		end
	endtask

	task automatic report_mismatch(input string what);
		$display("tb: mismatch at %0t: %s", $time, what);
		errors++;
	endtask

	// ---------------------------------------------------------------
	// Sender: bursts of items with random gaps
	// ---------------------------------------------------------------
	int burst_left = 0;
	int gap_left   = 0;

	always @(posedge clk) begin : sender
		drow_t nxt;
		if (arst_n) begin
			if (!txt_valid || !txt_stall) begin
				if (gap_left > 0) begin
					gap_left  <= gap_left - 1;
					txt_valid <= 1'b0;
				end else if (stim_q.size() > 0) begin
					nxt = stim_q.pop_front();
					cur_row   <= nxt;
					txt_data  <= nxt.it;
					txt_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 24);
						gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					txt_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Receiver: stall pattern by mode, plus one long hold-off
	// ---------------------------------------------------------------
	int   hold_left = 0;
	logic hold_done = 1'b0;

	always @(posedge clk) begin : receiver
		static int mode      = 0;
		static int mode_left = 0;
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				res_stall <= 1'b1;
			end else if (!hold_done && n_taken >= 150) begin
				hold_done <= 1'b1;
				hold_left <= 300;
				res_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode      = $urandom_range(0, 2);
					mode_left = $urandom_range(10, 60);
				end else begin
					mode_left--;
				end
				case (mode)
					0:       res_stall <= 1'b0;
					1:       res_stall <= 1'($urandom_range(0, 1));
					default: res_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	// ---------------------------------------------------------------
	// Monitor: predict on each accepted item, check each accepted result
	// ---------------------------------------------------------------
	always @(posedge clk) begin : monitor
		res_item_t want;
		if (arst_n) begin
			if (txt_valid && !txt_stall) begin
				n_taken++;
				decode_item(cur_row.it);
				if (cur_row.typed) begin
					if (cur_row.has_res)
						bytes_due.insert(bytes_due.size(), cur_row.res);
				end else begin
					for (int i = 0; i < pend_n; i++)
						bytes_due.insert(bytes_due.size(), pend[i]);
				end
			end
			if (res_valid && !res_stall) begin
				if (bytes_due.size() == 0) begin
					report_mismatch($sformatf("unexpected result %h/%0d/%0d",
						res_data.out_byte, res_data.kind, res_data.last));
				end else begin
					want = bytes_due.pop_front();
					if (res_data.out_byte !== want.out_byte)
						report_mismatch($sformatf("out_byte %h, want %h",
							res_data.out_byte, want.out_byte));
					if (res_data.kind !== want.kind)
						report_mismatch($sformatf("kind %0d, want %0d",
							res_data.kind, want.kind));
					if (res_data.last !== want.last)
						report_mismatch($sformatf("last %0d, want %0d",
							res_data.last, want.last));
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	drow_t dir_tab [N_DIRECTED];

	initial begin
		arst_n = 1'b0;

		dir_tab = '{
			ty0(8'h5A, 1'b1),                            // end while awaiting: nothing
			ty1(8'hFF, 1'b0, 8'h00, KIND_NOQUOTE),       // no opening quote
			ty0(CH_QUOTE, 1'b0),
			ty1(8'h00, 1'b0, 8'h00, KIND_BYTE),
			ty1(8'hFF, 1'b0, 8'hFF, KIND_BYTE),
			pd(CH_BSLASH, 1'b0),
			ty1(CH_N, 1'b0, 8'h0A, KIND_BYTE),
			// surrogate pair D83D DE00
			pd(CH_BSLASH, 1'b0), pd(CH_U, 1'b0),
			pd("D", 1'b0), pd("8", 1'b0), pd("3", 1'b0), pd("D", 1'b0),
			pd(CH_BSLASH, 1'b0), pd(CH_U, 1'b0),
			pd("d", 1'b0), pd("E", 1'b0), pd("0", 1'b0), pd("0", 1'b0),
			// quote in a digit slot, then end inside the digits
			pd(CH_BSLASH, 1'b0), pd(CH_U, 1'b0),
			pd(CH_QUOTE, 1'b0), pd("4", 1'b0), pd("1", 1'b0),
			ty1(8'h00, 1'b1, 8'h00, KIND_SHORT),
			// unterminated string
			ty0(CH_QUOTE, 1'b0),
			ty1(8'hA5, 1'b1, 8'h00, KIND_UNTERM)
		};
		foreach (dir_tab[i])
			stim_q.insert(stim_q.size(), dir_tab[i]);
		while (stim_q.size() < N_DIRECTED + N_RANDOM)
			gen_text();
		n_total = stim_q.size();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (n_taken < n_total)
			@(posedge clk);
		while (bytes_due.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire
